/* hdl/rsws_pkg.sv */
// Shared constants, codes and types for the reservation station.
// No dependencies; imported by rsws_ctrl, rsws_dp and the top level.
package rsws_pkg;

  localparam int DEPTH    = 8;
  localparam int TAG_BITS = 6;
  localparam int ID_BITS  = 16;
  localparam int VAL_W    = 32;
  localparam int CAP_W    = 4;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 4;
  localparam int OID_W    = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BROADCAST = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MARK_EXEC = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the input beat
    logic exec;       // apply a single-result action, load the output
    logic scan_clear; // start a query scan at the oldest entry
    logic scan_step;  // advance the scan index
    logic scan_emit;  // load the entry under the scan index to the output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic any_ready;
    logic out_free;
    logic cur_ready;
    logic cur_last;
  } stat_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [ID_BITS-1:0]  id;
    logic                wait1;
    logic [TAG_BITS-1:0] tag1;
    logic [VAL_W-1:0]    val1;
    logic                wait2;
    logic [TAG_BITS-1:0] tag2;
    logic [VAL_W-1:0]    val2;
    logic [TAG_BITS-1:0] btag;
    logic [VAL_W-1:0]    bval;
  } item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic                wait1;
    logic [TAG_BITS-1:0] tag1;
    logic [VAL_W-1:0]    val1;
    logic                wait2;
    logic [TAG_BITS-1:0] tag2;
    logic [VAL_W-1:0]    val2;
    logic                busy;
  } entry_t;

endpackage

/* hdl/rsws_ctrl.sv */
// Sequencer for the reservation station: accept, execute, query scan.
// Depends on rsws_pkg; drives rsws_dp through cmd_t, reads stat_t.
module rsws_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rsws_pkg::stat_t st,
  output rsws_pkg::cmd_t  cmd
);
  import rsws_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.is_query && st.any_ready) begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end else if (st.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!st.cur_ready) begin
          cmd.scan_step = 1'b1;
        end else if (st.out_free) begin
          cmd.scan_emit = 1'b1;
          cmd.scan_step = 1'b1;
          if (st.cur_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/rsws_dp.sv */
// Datapath: entry file, capacity register, output register and scan index.
// Depends on rsws_pkg; commanded by rsws_ctrl.
module rsws_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rsws_pkg::cmd_t                cmd,
  output rsws_pkg::stat_t               st,
  input  logic                          cfg_we,
  input  logic [rsws_pkg::CAP_W-1:0]    cfg_wdata,
  input  rsws_pkg::item_t               item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsws_pkg::STAT_W-1:0]   status,
  output logic [rsws_pkg::OID_W-1:0]    ready_id,
  output logic [rsws_pkg::VAL_W-1:0]    ready_value1,
  output logic [rsws_pkg::VAL_W-1:0]    ready_value2,
  output logic                          last,
  output logic [rsws_pkg::OCC_W-1:0]    occupancy
);
  import rsws_pkg::*;

  item_t              item_q;
  entry_t             entries [DEPTH];
  entry_t             entries_next [DEPTH];
  logic [CNT_W-1:0]   held, held_next;
  logic [CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]   limit;
  logic [IDX_W-1:0]   scan_idx;
  logic [DEPTH-1:0]   ready_mask;
  logic               hit;
  logic [IDX_W-1:0]   pos;
  logic [STAT_W-1:0]  res_status;
  logic               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
  end

  always_comb begin
    if (32'(capacity) < DEPTH) begin
      limit = CNT_W'(capacity);
    end else begin
      limit = CNT_W'(DEPTH);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ready_mask[i] = (CNT_W'(i) < held) && !entries[i].wait1 &&
                      !entries[i].wait2 && !entries[i].busy;
    end
  end

  // oldest entry holding the id
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!hit && (CNT_W'(i) < held) && (entries[i].id == item_q.id)) begin
        hit = 1'b1;
        pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    entries_next = entries;
    held_next    = held;
    res_status   = ST_OK;
    if (cmd.exec) begin
      unique case (item_q.action)
        ACT_INSERT: begin
          if (held >= limit) begin
            res_status = ST_FULL;
          end else begin
            entries_next[held[IDX_W-1:0]] = '{id: item_q.id,
                                              wait1: item_q.wait1,
                                              tag1: item_q.tag1,
                                              val1: item_q.val1,
                                              wait2: item_q.wait2,
                                              tag2: item_q.tag2,
                                              val2: item_q.val2,
                                              busy: 1'b0};
            held_next = held + CNT_W'(1);
          end
        end
        ACT_BROADCAST: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (entries[i].wait1 && entries[i].tag1 == item_q.btag) begin
              entries_next[i].wait1 = 1'b0;
              entries_next[i].val1  = item_q.bval;
            end
            if (entries[i].wait2 && entries[i].tag2 == item_q.btag) begin
              entries_next[i].wait2 = 1'b0;
              entries_next[i].val2  = item_q.bval;
            end
          end
        end
        ACT_QUERY: begin
          res_status = ST_NONE;
        end
        ACT_REMOVE: begin
          if (!hit) begin
            res_status = ST_NOT_FOUND;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (i >= int'(pos) && i + 1 < DEPTH) begin
                entries_next[i] = entries[(i + 1 < DEPTH) ? i + 1 : i];
              end
            end
            held_next = held - CNT_W'(1);
          end
        end
        ACT_MARK_EXEC: begin
          if (!hit) begin
            res_status = ST_NOT_FOUND;
          end else begin
            entries_next[pos].busy = 1'b1;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // output register
  assign out_valid_next = (cmd.exec || cmd.scan_emit) ? 1'b1 :
                          (out_stall ? out_valid : 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= res_status;
      ready_id     <= '0;
      ready_value1 <= '0;
      ready_value2 <= '0;
      last         <= 1'b1;
      occupancy    <= OCC_W'(held_next);
    end else if (cmd.scan_emit) begin
      status       <= ST_OK;
      ready_id     <= OID_W'(entries[scan_idx].id);
      ready_value1 <= entries[scan_idx].val1;
      ready_value2 <= entries[scan_idx].val2;
      last         <= st.cur_last;
      occupancy    <= OCC_W'(held);
    end
  end

  assign st.is_query  = (item_q.action == ACT_QUERY);
  assign st.any_ready = |ready_mask;
  assign st.out_free  = !out_valid || !out_stall;
  assign st.cur_ready = ready_mask[scan_idx];
  assign st.cur_last  = ((ready_mask >> scan_idx) == DEPTH'(1));

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_held_step: assert property (@(posedge clk) disable iff (rst)
    held == $past(held) || held == $past(held) + CNT_W'(1) ||
    held == $past(held) - CNT_W'(1))
    else $error("held count moved by more than one");

  a_emit_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_emit |-> st.cur_ready && st.out_free)
    else $error("scan emitted an entry that is not ready");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result dropped under stall");

endmodule

/* hdl/reservation_station_wakeup_select.sv */
// Top level of the ordered reservation station with tag wakeup and select.
// Depends on rsws_pkg, rsws_ctrl and rsws_dp.
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  -----------------------------------
//  input     in         in_valid / in_stall   action, instr_id, src1_*, src2_*,
//                                             bcast_tag, bcast_value
//  result    out        out_valid / out_stall status, ready_id, ready_value1/2,
//                                             last, occupancy
//  config    in         cfg_we                cfg_wdata (capacity)
//
// One item at a time. A beat is taken in the idle state and executed from the
// exec state: insert, broadcast, remove, mark-executing and an empty query end
// there once the output register is free. A query with ready entries then walks
// the entry file one slot per cycle with the scan counter, holding on a ready
// entry while the result side stalls, emitting each ready entry up to the newest.
// Reset (rst, synchronous) empties the station and sets capacity to 8; entry
// contents are not cleared; only slots below the held count ever affect a result.
// A stalled result holds in the output register; the block waits before it
// loads the next one, and the input stays stalled until the item is finished.
module reservation_station_wakeup_select (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [rsws_pkg::CAP_W-1:0]      cfg_wdata,
  // input beat
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rsws_pkg::ACT_W-1:0]      action,
  input  logic [rsws_pkg::ID_BITS-1:0]    instr_id,
  input  logic                            src1_waiting,
  input  logic [rsws_pkg::TAG_BITS-1:0]   src1_tag,
  input  logic [rsws_pkg::VAL_W-1:0]      src1_value,
  input  logic                            src2_waiting,
  input  logic [rsws_pkg::TAG_BITS-1:0]   src2_tag,
  input  logic [rsws_pkg::VAL_W-1:0]      src2_value,
  input  logic [rsws_pkg::TAG_BITS-1:0]   bcast_tag,
  input  logic [rsws_pkg::VAL_W-1:0]      bcast_value,
  // result beat
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rsws_pkg::STAT_W-1:0]     status,
  output logic [rsws_pkg::OID_W-1:0]      ready_id,
  output logic [rsws_pkg::VAL_W-1:0]      ready_value1,
  output logic [rsws_pkg::VAL_W-1:0]      ready_value2,
  output logic                            last,
  output logic [rsws_pkg::OCC_W-1:0]      occupancy
);
  import rsws_pkg::*;

  cmd_t  cmd;
  stat_t st;
  item_t item;

  // pack the input beat; the datapath captures it on cmd.latch
  assign item = '{action: action, id: instr_id,
                  wait1: src1_waiting, tag1: src1_tag, val1: src1_value,
                  wait2: src2_waiting, tag2: src2_tag, val2: src2_value,
                  btag: bcast_tag, bval: bcast_value};

  // sequencer: idle -> exec -> (scan) -> idle
  rsws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // entry file, parallel tag/id compares, compaction and output register
  rsws_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item         (item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .ready_id     (ready_id),
    .ready_value1 (ready_value1),
    .ready_value2 (ready_value2),
    .last         (last),
    .occupancy    (occupancy)
  );

endmodule

/* tb/sv/rsws_tb_pkg.sv */
// Shadow model of the reservation station plus the queue of expected result beats.
// Depends on rsws_pkg for widths, action and status codes, item_t and entry_t.
package rsws_tb_pkg;
  import rsws_pkg::*;

  // action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OID_W-1:0]  id;
    logic [VAL_W-1:0]  val1;
    logic [VAL_W-1:0]  val2;
    logic              last;
    logic [OCC_W-1:0]  occ;
  } rs_result_t;

  class station_shadow;
    entry_t           slots[DEPTH];
    int unsigned      held;
    logic [CAP_W-1:0] capacity;
    rs_result_t       expected_results[$];
    int unsigned      mismatches;

    function new();
      held       = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void queue_result(logic [STAT_W-1:0] st, logic [OID_W-1:0] id,
                               logic [VAL_W-1:0] v1, logic [VAL_W-1:0] v2, logic lst);
      rs_result_t r;
      r.status = st;
      r.id     = id;
      r.val1   = v1;
      r.val2   = v2;
      r.last   = lst;
      r.occ    = OCC_W'(held);
      expected_results = {expected_results, r};
    endfunction

    function int oldest_with_id(logic [ID_BITS-1:0] id);
      for (int i = 0; i < held; i++)
        if (slots[i].id == id) return i;
      return -1;
    endfunction

    // update the shadow state for one accepted input beat and queue its results
    function void apply_item(item_t it);
      int unsigned lim;
      int unsigned n;
      int          pos;
      lim = (capacity < DEPTH) ? capacity : DEPTH;
      n   = 0;
      case (it.action)
        ACT_INSERT: begin
          if (held >= lim) begin
            queue_result(ST_FULL, '0, '0, '0, 1'b1);
          end else begin
            slots[held].id    = it.id;
            slots[held].wait1 = it.wait1;
            slots[held].tag1  = it.tag1;
            slots[held].val1  = it.val1;
            slots[held].wait2 = it.wait2;
            slots[held].tag2  = it.tag2;
            slots[held].val2  = it.val2;
            slots[held].busy  = 1'b0;
            held++;
            queue_result(ST_OK, '0, '0, '0, 1'b1);
          end
        end
        ACT_BROADCAST: begin
          for (int i = 0; i < held; i++) begin
            if (slots[i].wait1 && slots[i].tag1 == it.btag) begin
              slots[i].wait1 = 1'b0;
              slots[i].val1  = it.bval;
            end
            if (slots[i].wait2 && slots[i].tag2 == it.btag) begin
              slots[i].wait2 = 1'b0;
              slots[i].val2  = it.bval;
            end
          end
          queue_result(ST_OK, '0, '0, '0, 1'b1);
        end
        ACT_QUERY: begin
          for (int i = 0; i < held; i++) begin
            if (!slots[i].wait1 && !slots[i].wait2 && !slots[i].busy) begin
              queue_result(ST_OK, slots[i].id, slots[i].val1, slots[i].val2, 1'b0);
              n++;
            end
          end
          if (n == 0) queue_result(ST_NONE, '0, '0, '0, 1'b1);
          else expected_results[expected_results.size() - 1].last = 1'b1;
        end
        ACT_REMOVE: begin
          pos = oldest_with_id(it.id);
          if (pos < 0) begin
            queue_result(ST_NOT_FOUND, '0, '0, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
            queue_result(ST_OK, '0, '0, '0, 1'b1);
          end
        end
        ACT_MARK_EXEC: begin
          pos = oldest_with_id(it.id);
          if (pos < 0) begin
            queue_result(ST_NOT_FOUND, '0, '0, '0, 1'b1);
          end else begin
            slots[pos].busy = 1'b1;
            queue_result(ST_OK, '0, '0, '0, 1'b1);
          end
        end
        default: queue_result(ST_OK, '0, '0, '0, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rs_result_t got);
      rs_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d id 0x%0h",
               got.status, got.id);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("ready_id", 32'(want.id), 32'(got.id));
      compare_field("ready_value1", want.val1, got.val1);
      compare_field("ready_value2", want.val2, got.val2);
      compare_field("last", 32'(want.last), 32'(got.last));
      compare_field("occupancy", 32'(want.occ), 32'(got.occ));
    endfunction
  endclass

endpackage

/* tb/sv/tb.sv */
// Self-checking bench for reservation_station_wakeup_select: directed then random
// beats under random sender gaps and receiver stalls. Depends on rsws_pkg, rsws_tb_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsws_pkg::*;
  import rsws_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_we       = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action       = ACT_QUERY;
  logic [ID_BITS-1:0]  instr_id     = '0;
  logic                src1_waiting = 1'b0;
  logic [TAG_BITS-1:0] src1_tag     = '0;
  logic [VAL_W-1:0]    src1_value   = '0;
  logic                src2_waiting = 1'b0;
  logic [TAG_BITS-1:0] src2_tag     = '0;
  logic [VAL_W-1:0]    src2_value   = '0;
  logic [TAG_BITS-1:0] bcast_tag    = '0;
  logic [VAL_W-1:0]    bcast_value  = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [OID_W-1:0]    ready_id;
  logic [VAL_W-1:0]    ready_value1;
  logic [VAL_W-1:0]    ready_value2;
  logic                last;
  logic [OCC_W-1:0]    occupancy;

  // shadow copy of the station; holds the expected result beats in order
  station_shadow station = new();

  // receiver stall pattern state
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;

  // sender burst state
  int unsigned burst_left = 0;

  reservation_station_wakeup_select i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .instr_id     (instr_id),
    .src1_waiting (src1_waiting),
    .src1_tag     (src1_tag),
    .src1_value   (src1_value),
    .src2_waiting (src2_waiting),
    .src2_tag     (src2_tag),
    .src2_value   (src2_value),
    .bcast_tag    (bcast_tag),
    .bcast_value  (bcast_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .ready_id     (ready_id),
    .ready_value1 (ready_value1),
    .ready_value2 (ready_value2),
    .last         (last),
    .occupancy    (occupancy)
  );

  always #1 clk = ~clk;

  // Receiver: switch between stall styles - none, light random, heavy random,
  // or a square wave from bit 2 of the cycle counter - so stalls land on every
  // phase of a query scan and also leave stretches with no back-pressure.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 48 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= rx_cycle[2];
    endcase
  end

  // Result monitor. Reads happen in the active region at the edge, before any
  // nonblocking update, so they see the values the handshake was decided on.
  always @(posedge clk) begin : watch_results
    rs_result_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.status = status;
      seen.id     = ready_id;
      seen.val1   = ready_value1;
      seen.val2   = ready_value2;
      seen.last   = last;
      seen.occ    = occupancy;
      station.check_result(seen);
    end
  end

  // Tags mostly from a tiny pool so broadcasts actually hit waiting sources.
  function automatic logic [TAG_BITS-1:0] pick_tag();
    if ($urandom_range(0, 9) < 7) return TAG_BITS'($urandom_range(0, 3));
    return TAG_BITS'($urandom());
  endfunction

  // Every field but the action random (action is a query); ids often from a small pool to get duplicates.
  function automatic item_t filler_item();
    item_t it;
    it.action = ACT_QUERY;
    if ($urandom_range(0, 1) != 0) it.id = ID_BITS'($urandom_range(0, 15));
    else it.id = ID_BITS'($urandom());
    it.wait1 = 1'($urandom_range(0, 1));
    it.tag1  = pick_tag();
    it.val1  = $urandom();
    it.wait2 = 1'($urandom_range(0, 1));
    it.tag2  = pick_tag();
    it.val2  = $urandom();
    it.btag  = pick_tag();
    it.bval  = $urandom();
    return it;
  endfunction

  function automatic item_t insert_item(logic [ID_BITS-1:0] id,
                                        logic w1, logic [TAG_BITS-1:0] t1,
                                        logic [VAL_W-1:0] v1,
                                        logic w2, logic [TAG_BITS-1:0] t2,
                                        logic [VAL_W-1:0] v2);
    item_t it;
    it        = filler_item();
    it.action = ACT_INSERT;
    it.id     = id;
    it.wait1  = w1;
    it.tag1   = t1;
    it.val1   = v1;
    it.wait2  = w2;
    it.tag2   = t2;
    it.val2   = v2;
    return it;
  endfunction

  function automatic item_t control_item(logic [ACT_W-1:0] act, logic [ID_BITS-1:0] id,
                                         logic [TAG_BITS-1:0] bt, logic [VAL_W-1:0] bv);
    item_t it;
    it        = filler_item();
    it.action = act;
    it.id     = id;
    it.btag   = bt;
    it.bval   = bv;
    return it;
  endfunction

  // Random beat aimed at the live contents: removes and marks mostly name an
  // id that is held, broadcasts mostly carry a source tag of a held entry.
  function automatic item_t random_item();
    item_t       it;
    int unsigned roll;
    int unsigned k;
    it   = filler_item();
    roll = $urandom_range(0, 99);
    if (roll < 32) it.action = ACT_INSERT;
    else if (roll < 55) it.action = ACT_BROADCAST;
    else if (roll < 70) it.action = ACT_QUERY;
    else if (roll < 84) it.action = ACT_REMOVE;
    else if (roll < 95) it.action = ACT_MARK_EXEC;
    else it.action = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    if (station.held > 0) begin
      k = $urandom_range(0, station.held - 1);
      if (it.action == ACT_BROADCAST && $urandom_range(0, 9) < 7)
        it.btag = station.slots[k].wait1 ? station.slots[k].tag1 : station.slots[k].tag2;
      if ((it.action == ACT_REMOVE || it.action == ACT_MARK_EXEC) &&
          $urandom_range(0, 9) < 8)
        it.id = station.slots[k].id;
    end
    return it;
  endfunction

  // Present one beat and hold it until the block takes it. Called at an edge.
  task automatic push_item(input item_t it);
    in_valid     <= 1'b1;
    action       <= it.action;
    instr_id     <= it.id;
    src1_waiting <= it.wait1;
    src1_tag     <= it.tag1;
    src1_value   <= it.val1;
    src2_waiting <= it.wait2;
    src2_tag     <= it.tag2;
    src2_value   <= it.val2;
    bcast_tag    <= it.btag;
    bcast_value  <= it.bval;
    do @(posedge clk); while (in_stall !== 1'b0);
    station.apply_item(it);
  endtask

  // Sender with bursts: random-length runs of back-to-back beats, random gaps.
  task automatic push_with_gaps(input item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    push_item(it);
    burst_left--;
  endtask

  // Stop sending and wait for every expected result beat. Checked at the
  // falling edge so the outcome never depends on process order at the edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (station.expected_results.size() != 0);
    @(posedge clk);
  endtask

  // Capacity is only written with the station idle and nothing outstanding.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we           <= 1'b0;
    station.capacity = cap;
  endtask

  task automatic run_directed();
    // empty station: query finds nothing, remove and mark miss
    push_item(control_item(ACT_QUERY, 16'h0042, pick_tag(), $urandom()));
    push_item(control_item(ACT_REMOVE, 16'h0042, pick_tag(), $urandom()));
    push_item(control_item(ACT_MARK_EXEC, 16'h0042, pick_tag(), $urandom()));
    // both sources wait on the same tag; one broadcast must wake both
    push_item(insert_item(16'hFFFF, 1'b1, 6'h3F, 32'hFFFF_FFFF, 1'b1, 6'h3F, 32'h0));
    // ready entry whose src1 tag equals a later broadcast: value must stay
    push_item(insert_item(16'h0000, 1'b0, 6'h3F, 32'h0, 1'b0, 6'h00, 32'hFFFF_FFFF));
    // duplicate id; src2 not waiting but carries the broadcast tag
    push_item(insert_item(16'h0000, 1'b1, 6'h00, 32'h1111_1111, 1'b0, 6'h00,
                          32'h2222_2222));
    push_item(control_item(ACT_QUERY, 16'hFFFF, pick_tag(), $urandom()));
    push_item(control_item(ACT_BROADCAST, 16'h0, 6'h3F, 32'hA5A5_A5A5));
    push_item(control_item(ACT_BROADCAST, 16'h0, 6'h00, 32'h5A5A_5A5A));
    push_item(control_item(ACT_QUERY, 16'h0, pick_tag(), $urandom()));
    // marking and removing hit the oldest of the duplicates
    push_item(control_item(ACT_MARK_EXEC, 16'h0000, pick_tag(), $urandom()));
    push_item(control_item(ACT_QUERY, 16'h0, pick_tag(), $urandom()));
    push_item(control_item(ACT_REMOVE, 16'h0000, pick_tag(), $urandom()));
    push_item(control_item(ACT_QUERY, 16'h0, pick_tag(), $urandom()));
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      push_item(control_item(ACT_W'(a), ID_BITS'($urandom()), pick_tag(), $urandom()));
    // broadcast nobody waits for
    push_item(control_item(ACT_BROADCAST, 16'h0, 6'h15, 32'hDEAD_0001));
    // fill to capacity with ready entries, one more is rejected as full
    for (int k = 0; k < 7; k++)
      push_item(insert_item(ID_BITS'(k * 4679 + 1), 1'b0, TAG_BITS'(k), $urandom(),
                            1'b0, TAG_BITS'(63 - k), $urandom()));
    // every slot ready: longest query stream
    push_item(control_item(ACT_QUERY, 16'h0, pick_tag(), $urandom()));
  endtask

  // Stimulus: reset, directed beats back to back, then random phases at
  // different capacities - zero (always full), one, the depth and above it.
  initial begin : stimulus
    logic [CAP_W-1:0] caps[6];
    caps = '{4'd3, 4'd1, 4'd0, 4'd15, 4'd8, 4'd6};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      burst_left = 0;
      repeat (68) push_with_gaps(random_item());
    end
    wait_drained();
    // wait idle to catch any stray result beat
    repeat (16) @(posedge clk);
    if (station.mismatches == 0) begin
      $display("reservation_station_wakeup_select verification clean");
    end else begin
      $display("reservation_station_wakeup_select verification failed");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs, reporting it as failed.
  initial begin : watchdog
    #400_000;
    $display("reservation_station_wakeup_select verification failed");
    $finish;
  end

endmodule

/* reservation_station_wakeup_select.f */
hdl/rsws_pkg.sv
hdl/rsws_ctrl.sv
hdl/rsws_dp.sv
hdl/reservation_station_wakeup_select.sv
tb/sv/rsws_tb_pkg.sv
tb/sv/tb.sv
